// File: sv/ebts_pkg.sv
// shared types and constants of the endpoint busy transfer scheduler
package ebts_pkg;

    localparam int TASK_W   = 16;
    localparam int EP_W     = 4;
    localparam int LAT_IN_W = 16;
    localparam int KIND_W   = 2;

    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [TASK_W-1:0] t_task;

    localparam logic  OP_ENQ  = 1'b0;
    localparam logic  OP_TICK = 1'b1;

    localparam t_kind KIND_REL  = 2'd0;
    localparam t_kind KIND_ACC  = 2'd1;
    localparam t_kind KIND_DROP = 2'd2;
    localparam t_kind KIND_TICK = 2'd3;

    typedef struct packed {
        t_kind kind;
        t_task task_id;
    } t_result;

endpackage

// File: sv/ebts_front.sv
// front end: word intake queue, endpoint wrap and latency saturation
module ebts_front #(
    parameter int NUM_MACHINES = 16,
    parameter int LATENCY_BITS = 16,
    parameter int MW           = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_operation,
    input  ebts_pkg::t_task        i_task_id,
    input  logic [ebts_pkg::EP_W-1:0]     i_source_machine,
    input  logic [ebts_pkg::EP_W-1:0]     i_dest_machine,
    input  logic [ebts_pkg::LAT_IN_W-1:0] i_transfer_latency,
    output logic                   o_item_valid,
    input  logic                   i_item_ready,
    output logic                   o_operation,
    output ebts_pkg::t_task        o_task_id,
    output logic [MW-1:0]          o_src,
    output logic [MW-1:0]          o_dst,
    output logic [LATENCY_BITS-1:0] o_lat
);
    import ebts_pkg::*;

    function automatic logic [MW-1:0] f_wrap(input logic [EP_W-1:0] ep);
        logic [8:0] v;
        v = {5'b0, ep};
        for (int k = 0; k < 8; k++) begin
            if (v >= 9'(NUM_MACHINES)) v = v - 9'(NUM_MACHINES);
        end
        return v[MW-1:0];
    endfunction

    function automatic logic [LATENCY_BITS-1:0] f_sat(input logic [LAT_IN_W-1:0] lat);
        logic [32:0] ext;
        logic [32:0] lmax;
        ext  = 33'(lat);
        lmax = (33'(1) << LATENCY_BITS) - 33'(1);
        if (ext > lmax) ext = lmax;
        return ext[LATENCY_BITS-1:0];
    endfunction

    logic                    r_q_op   [2];
    t_task                   r_q_task [2];
    logic [MW-1:0]           r_q_src  [2];
    logic [MW-1:0]           r_q_dst  [2];
    logic [LATENCY_BITS-1:0] r_q_lat  [2];
    logic                    r_wp;
    logic                    r_rp;
    logic [1:0]              r_cnt;

    logic w_push;
    logic w_pop;

    assign o_in_ready   = (r_cnt != 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign w_push       = i_in_valid && o_in_ready;
    assign w_pop        = o_item_valid && i_item_ready;

    assign o_operation = r_q_op[r_rp];
    assign o_task_id   = r_q_task[r_rp];
    assign o_src       = r_q_src[r_rp];
    assign o_dst       = r_q_dst[r_rp];
    assign o_lat       = r_q_lat[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_op[r_wp]   <= i_operation;
            r_q_task[r_wp] <= i_task_id;
            r_q_src[r_wp]  <= f_wrap(i_source_machine);
            r_q_dst[r_wp]  <= f_wrap(i_dest_machine);
            r_q_lat[r_wp]  <= f_sat(i_transfer_latency);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

// File: sv/ebts_back.sv
// back end: pending queue, in-flight table, tick sequencer and result buffer
module ebts_back #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int NUM_MACHINES = 16,
    parameter int LATENCY_BITS = 16,
    parameter int MW           = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_wdata,
    input  logic                    i_item_valid,
    output logic                    o_item_ready,
    input  logic                    i_operation,
    input  ebts_pkg::t_task         i_task_id,
    input  logic [MW-1:0]           i_src,
    input  logic [MW-1:0]           i_dst,
    input  logic [LATENCY_BITS-1:0] i_lat,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output ebts_pkg::t_kind         o_kind,
    output ebts_pkg::t_task         o_released_task,
    output logic                    o_idle,
    output logic                    o_last
);
    import ebts_pkg::*;

    localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int RD  = NUM_MACHINES + QUEUE_DEPTH + 1;
    localparam int RIW = $clog2(RD);
    localparam int RCW = $clog2(RD + 1);
    localparam int PW  = TASK_W + 2 * MW + LATENCY_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_CNT, S_REL, S_PRD, S_PPROC, S_FIN, S_ORD, S_OUT
    } t_state;

    t_state                  r_state;
    logic                    r_lat_en;
    logic [CW-1:0]           r_cnt;
    logic [CW-1:0]           r_pi;
    logic [CW-1:0]           r_keep;
    logic                    r_fv     [NUM_MACHINES];
    logic                    r_done   [NUM_MACHINES];
    t_task                   r_ftask  [NUM_MACHINES];
    logic [LATENCY_BITS-1:0] r_fleft  [NUM_MACHINES];
    logic [LATENCY_BITS-1:0] r_busy   [NUM_MACHINES];
    logic [MW-1:0]           r_si;
    logic                    r_found;
    logic [MW-1:0]           r_best;
    t_task                   r_best_task;
    logic [RCW-1:0]          r_wp;
    logic [RCW-1:0]          r_rp;
    logic                    r_idle;
    logic                    r_last;

    logic [PW-1:0]           r_pq [QUEUE_DEPTH];
    logic [PW-1:0]           r_pq_q;
    t_result                 r_rb [RD];
    t_result                 r_rb_q;

    // pending entry fields
    t_task                   w_p_task;
    logic [MW-1:0]           w_p_src;
    logic [MW-1:0]           w_p_dst;
    logic [LATENCY_BITS-1:0] w_p_lat;
    assign {w_p_task, w_p_src, w_p_dst, w_p_lat} = r_pq_q;

    logic                    w_take;
    logic [MW-1:0]           w_bi;
    t_task                   w_bt;
    logic                    w_bf;
    logic                    w_last_e;
    logic                    w_free;
    logic                    w_slot_ok;
    logic [MW-1:0]           w_slot;
    logic                    w_any_fv;
    logic                    w_pq_we;
    logic [QIW-1:0]          w_pq_wa;
    logic [PW-1:0]           w_pq_wd;
    logic                    w_rb_we;
    t_result                 w_rb_wd;

    assign o_item_ready = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_kind          = r_rb_q.kind;
    assign o_released_task = r_rb_q.task_id;
    assign o_idle          = r_idle;
    assign o_last          = r_last;

    // running minimum over the done entries
    assign w_take   = r_done[r_si] && (!r_found || (r_ftask[r_si] < r_best_task));
    assign w_bi     = w_take ? r_si : r_best;
    assign w_bt     = w_take ? r_ftask[r_si] : r_best_task;
    assign w_bf     = r_found || w_take;
    assign w_last_e = (r_si == MW'(NUM_MACHINES - 1));

    assign w_free = (r_busy[w_p_src] == '0) && (r_busy[w_p_dst] == '0);

    always_comb begin
        w_slot_ok = 1'b0;
        w_slot    = '0;
        w_any_fv  = 1'b0;
        for (int j = NUM_MACHINES - 1; j >= 0; j--) begin
            if (!r_fv[j]) begin
                w_slot_ok = 1'b1;
                w_slot    = MW'(j);
            end
            if (r_fv[j]) w_any_fv = 1'b1;
        end
    end

    // memory write ports
    always_comb begin
        w_pq_we = 1'b0;
        w_pq_wa = r_cnt[QIW-1:0];
        w_pq_wd = {i_task_id, i_src, i_dst, i_lat};
        w_rb_we = 1'b0;
        w_rb_wd = '{kind: KIND_TICK, task_id: '0};
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid && i_operation == OP_ENQ) begin
                    w_rb_we = 1'b1;
                    if (r_cnt == CW'(QUEUE_DEPTH)) begin
                        w_rb_wd = '{kind: KIND_DROP, task_id: i_task_id};
                    end else begin
                        w_rb_wd = '{kind: KIND_ACC, task_id: i_task_id};
                        w_pq_we = 1'b1;
                    end
                end
            end
            S_REL: begin
                if (w_last_e && w_bf) begin
                    w_rb_we = 1'b1;
                    w_rb_wd = '{kind: KIND_REL, task_id: w_bt};
                end
            end
            S_PPROC: begin
                if (!r_lat_en || (w_free && (w_p_lat == '0 || !w_slot_ok))) begin
                    w_rb_we = 1'b1;
                    w_rb_wd = '{kind: KIND_REL, task_id: w_p_task};
                end else if (!w_free) begin
                    w_pq_we = 1'b1;
                    w_pq_wa = r_keep[QIW-1:0];
                    w_pq_wd = r_pq_q;
                end
            end
            S_FIN: begin
                w_rb_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_pq_we) r_pq[w_pq_wa] <= w_pq_wd;
        if (r_state == S_PRD) r_pq_q <= r_pq[r_pi[QIW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_rb_we) r_rb[r_wp[RIW-1:0]] <= w_rb_wd;
        if (r_state == S_ORD) r_rb_q <= r_rb[r_rp[RIW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lat_en    <= 1'b1;
            r_cnt       <= '0;
            r_pi        <= '0;
            r_keep      <= '0;
            r_si        <= '0;
            r_found     <= 1'b0;
            r_best      <= '0;
            r_best_task <= '0;
            r_wp        <= '0;
            r_rp        <= '0;
            r_idle      <= 1'b1;
            r_last      <= 1'b0;
            for (int i = 0; i < NUM_MACHINES; i++) begin
                r_fv[i]   <= 1'b0;
                r_done[i] <= 1'b0;
                r_busy[i] <= '0;
            end
        end else begin
            if (i_cfg_we) r_lat_en <= i_cfg_wdata;
            if (w_rb_we) r_wp <= r_wp + RCW'(1);
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        if (i_operation == OP_ENQ) begin
                            if (r_cnt != CW'(QUEUE_DEPTH)) r_cnt <= r_cnt + CW'(1);
                            // queue holds at least one transfer afterwards
                            r_idle  <= 1'b0;
                            r_state <= S_ORD;
                        end else begin
                            r_state <= S_CNT;
                        end
                    end
                end
                S_CNT: begin
                    for (int i = 0; i < NUM_MACHINES; i++) begin
                        if (r_busy[i] != '0) r_busy[i] <= r_busy[i] - LATENCY_BITS'(1);
                        if (r_fv[i] && r_fleft[i] != '0) begin
                            r_fleft[i] <= r_fleft[i] - LATENCY_BITS'(1);
                        end
                        r_done[i] <= r_fv[i] && (r_fleft[i] <= LATENCY_BITS'(1));
                    end
                    r_si    <= '0;
                    r_found <= 1'b0;
                    r_state <= S_REL;
                end
                S_REL: begin
                    if (w_last_e) begin
                        r_si    <= '0;
                        r_found <= 1'b0;
                        if (w_bf) begin
                            r_fv[w_bi]   <= 1'b0;
                            r_done[w_bi] <= 1'b0;
                        end else begin
                            r_pi    <= '0;
                            r_keep  <= '0;
                            r_state <= S_PRD;
                        end
                    end else begin
                        r_si        <= r_si + MW'(1);
                        r_found     <= w_bf;
                        r_best      <= w_bi;
                        r_best_task <= w_bt;
                    end
                end
                S_PRD: begin
                    r_state <= (r_pi == r_cnt) ? S_FIN : S_PPROC;
                end
                S_PPROC: begin
                    if (r_lat_en && w_free && w_p_lat != '0 && w_slot_ok) begin
                        r_fv[w_slot]    <= 1'b1;
                        r_ftask[w_slot] <= w_p_task;
                        r_fleft[w_slot] <= w_p_lat;
                        r_busy[w_p_src] <= w_p_lat;
                        r_busy[w_p_dst] <= w_p_lat;
                    end else if (r_lat_en && !w_free) begin
                        r_keep <= r_keep + CW'(1);
                    end
                    r_pi    <= r_pi + CW'(1);
                    r_state <= S_PRD;
                end
                S_FIN: begin
                    r_cnt   <= r_keep;
                    r_idle  <= (r_keep == '0) && !w_any_fv;
                    r_state <= S_ORD;
                end
                S_ORD: begin
                    r_last  <= ((r_rp + RCW'(1)) == r_wp);
                    r_rp    <= r_rp + RCW'(1);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        if (r_last) begin
                            r_wp    <= '0;
                            r_rp    <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_ORD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: sv/endpoint_busy_transfer_scheduler_core.sv
// top level of the endpoint busy transfer scheduler
//
// input channel: i_in_valid / o_in_ready carry one word, either an enqueue
// (operation 0) or a tick (operation 1); output channel: o_out_valid /
// i_out_ready carry result words with kind, released_task, idle and last.
// a two-word intake queue takes words while the back end works.
// enqueue: one result, accept or drop, read out via S_ORD and S_OUT.
// tick: a countdown state, then release passes over the in-flight table
// (releases + 1 passes, each a sequential minimum search over the table),
// S_PRD / S_PPROC per pending entry scanned, closing S_PRD and S_FIN, then
// results are drained from the result buffer through S_ORD and S_OUT.
// results of a word leave only after the whole word is handled, since idle
// reflects the final state; a stalled receiver holds the back end, and the
// intake queue keeps taking words until it is full. synchronous active-low
// reset empties both queues, clears the in-flight table and busy timers,
// and sets latency_enable to 1. the user is to write latency_enable via
// i_cfg_we / i_cfg_wdata while the block is idle; it does not enforce this.
module endpoint_busy_transfer_scheduler_core #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int NUM_MACHINES = 16,
    parameter int LATENCY_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_operation,
    input  ebts_pkg::t_task               i_task_id,
    input  logic [ebts_pkg::EP_W-1:0]     i_source_machine,
    input  logic [ebts_pkg::EP_W-1:0]     i_dest_machine,
    input  logic [ebts_pkg::LAT_IN_W-1:0] i_transfer_latency,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ebts_pkg::t_kind               o_kind,
    output ebts_pkg::t_task               o_released_task,
    output logic                          o_idle,
    output logic                          o_last
);
    import ebts_pkg::*;

    localparam int MW = $clog2(NUM_MACHINES);

    logic                    w_item_valid;
    logic                    w_item_ready;
    logic                    w_op;
    t_task                   w_task;
    logic [MW-1:0]           w_src;
    logic [MW-1:0]           w_dst;
    logic [LATENCY_BITS-1:0] w_lat;

    ebts_front #(
        .NUM_MACHINES(NUM_MACHINES),
        .LATENCY_BITS(LATENCY_BITS),
        .MW(MW)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_operation(i_operation),
        .i_task_id(i_task_id),
        .i_source_machine(i_source_machine),
        .i_dest_machine(i_dest_machine),
        .i_transfer_latency(i_transfer_latency),
        .o_item_valid(w_item_valid),
        .i_item_ready(w_item_ready),
        .o_operation(w_op),
        .o_task_id(w_task),
        .o_src(w_src),
        .o_dst(w_dst),
        .o_lat(w_lat)
    );

    ebts_back #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .NUM_MACHINES(NUM_MACHINES),
        .LATENCY_BITS(LATENCY_BITS),
        .MW(MW)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_item_valid(w_item_valid),
        .o_item_ready(w_item_ready),
        .i_operation(w_op),
        .i_task_id(w_task),
        .i_src(w_src),
        .i_dst(w_dst),
        .i_lat(w_lat),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_kind(o_kind),
        .o_released_task(o_released_task),
        .o_idle(o_idle),
        .o_last(o_last)
    );

endmodule
